>>> hw/rtl/lnf_pkg.sv
// ----------------------------------------------------------------------------
// LFSR noise FIR filter package
// Shared widths, reset values, request and register codes, and the control
// bundle that drives the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package lnf_pkg;

	// Data widths of the sample path and the configuration registers.
	localparam int DATA_W    = 16;
	localparam int Q_FRAC    = 15;
	localparam int NOISE_W   = 15;
	localparam int TAPS_W    = 7;
	localparam int COEF_IX_W = 6;
	localparam int CFG_IX_W  = 1;

	// Default filter length.
	localparam int MAX_TAPS_DEF = 64;

	// Reset values.
	localparam logic [DATA_W-1:0]  LFSR_SEED   = 16'hFFFF;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 15'd8000;
	localparam logic [TAPS_W-1:0]  TAPS_RESET  = 7'd41;

	// Saturation limits of the output sample.
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	// Request codes carried by req_type.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_COEF = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] CFG_NOISE_LEVEL = 1'b0;
	localparam logic [CFG_IX_W-1:0] CFG_TAPS_IN_USE = 1'b1;

	// Control bundle for the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

>>> hw/rtl/lnf_mac.sv
// ----------------------------------------------------------------------------
// LFSR noise FIR multiply-accumulate unit
// One signed 16x16 multiplier with a registered product, followed by a wide
// accumulator. Used once per tap under control of the top-level sequencer.
// ----------------------------------------------------------------------------
module lnf_mac #(
	parameter int ACC_W = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lnf_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [lnf_pkg::DATA_W-1:0]   a,
	input  logic signed [lnf_pkg::DATA_W-1:0]   b,
	output logic signed [ACC_W-1:0]             acc,
	output logic                                busy
);
	import lnf_pkg::*;

	logic signed [2*DATA_W-1:0] prod_s2;
	logic                       v_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// Product register; the payload needs no reset.
	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	// Product valid flag and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s2 <= ctrl.valid;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s2;

endmodule

>>> hw/rtl/lfsr_noise_fir_filter.sv
// ----------------------------------------------------------------------------
// LFSR noise FIR filter
// A 16-bit LFSR makes a plus or minus noise sample on each sample tick; the
// sample enters a delay line and an FIR sum over the programmed taps gives a
// saturated 16-bit output sample. Coefficient writes load the Q15 table.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  ------------------------------------
//   in       in_valid / in_stall   req_type, coef_index, coef_value
//   out      out_valid / out_stall sample
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A coefficient write leaves the block ready.
// A sample tick runs min(taps_in_use, MAX_TAPS) multiply-accumulates, one per tap,
// through the single shared multiplier.
// Reset clears the valid bits of both tables at once; no clearing pass.
// A stalled output beat holds the finished sample; the next input beat is
// still taken, and a new result waits until the output register frees.
// ----------------------------------------------------------------------------
module lfsr_noise_fir_filter #(
	parameter int MAX_TAPS = lnf_pkg::MAX_TAPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic [lnf_pkg::COEF_IX_W-1:0]          coef_index,
	input  logic signed [lnf_pkg::DATA_W-1:0]      coef_value,
	// Output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lnf_pkg::DATA_W-1:0]      sample,
	// Configuration channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lnf_pkg::CFG_IX_W-1:0]           cfg_index,
	input  logic [lnf_pkg::NOISE_W-1:0]            cfg_data
);
	import lnf_pkg::*;

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int TW    = (CW > TAPS_W) ? CW : TAPS_W;
	localparam int IXW   = (AW > COEF_IX_W) ? AW : COEF_IX_W;
	localparam int ACC_W = 2 * DATA_W + $clog2(MAX_TAPS);
	localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(SAMPLE_MIN);
	localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'((1 << Q_FRAC) - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                    state_q;
	logic [NOISE_W-1:0]        noise_level_q;
	logic [TAPS_W-1:0]         taps_q;
	logic [DATA_W-1:0]         lfsr_q;
	logic [AW-1:0]             wp_q;
	logic [AW-1:0]             rp_q;
	logic [CW-1:0]             k_q;
	logic [CW-1:0]             n_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  sample_q;

	logic [DATA_W-1:0]         dl_mem [MAX_TAPS];
	logic [DATA_W-1:0]         cf_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]       dl_vld_q;
	logic [MAX_TAPS-1:0]       cf_vld_q;

	logic [DATA_W-1:0]         dl_s1;
	logic [DATA_W-1:0]         cf_s1;
	logic                      dlv_s1;
	logic                      cfv_s1;
	logic                      issue_s1;

	logic                      in_acc;
	logic                      tick_acc;
	logic                      coef_acc;
	logic                      coef_ok;
	logic [IXW-1:0]            idx_ext;
	logic [AW-1:0]             coef_addr;
	logic                      fb;
	logic [DATA_W-1:0]         lvl_ext;
	logic [DATA_W-1:0]         noise;
	logic [TW-1:0]             taps_ext;
	logic [CW-1:0]             n_sel;
	logic                      issue;
	logic [AW-1:0]             tap_addr;
	logic signed [DATA_W-1:0]  op_a;
	logic signed [DATA_W-1:0]  op_b;
	mac_ctrl_t                 mac_ctrl;
	logic signed [ACC_W-1:0]   acc;
	logic                      mac_busy;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [ACC_W-1:0]   acc_shf;
	logic signed [DATA_W-1:0]  sat_val;
	logic                      out_free;
	logic                      finish;

	// Handshakes.
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign tick_acc  = in_acc && (req_type == REQ_TICK);
	assign coef_acc  = in_acc && (req_type == REQ_COEF);

	// Coefficient writes beyond the table are dropped.
	assign idx_ext   = IXW'(coef_index);
	assign coef_ok   = ({1'b0, idx_ext} < (IXW + 1)'(MAX_TAPS));
	assign coef_addr = AW'(idx_ext);

	// Noise sample from the current LFSR state and the next feedback bit.
	assign fb      = lfsr_q[0] ^ lfsr_q[1] ^ lfsr_q[11] ^ lfsr_q[13];
	assign lvl_ext = DATA_W'(noise_level_q);
	assign noise   = lfsr_q[0] ? (~lvl_ext + 1'b1) : lvl_ext;

	// Tap count, limited to the table length.
	assign taps_ext = TW'(taps_q);
	assign n_sel    = (taps_ext > TW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(taps_ext);

	// One tap read is issued per run cycle; tap k lives k entries behind the head.
	assign issue    = (state_q == ST_RUN) && (k_q != n_q);
	assign tap_addr = AW'(k_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_level_q <= NOISE_RESET;
			taps_q        <= TAPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NOISE_LEVEL: noise_level_q <= cfg_data;
				CFG_TAPS_IN_USE: taps_q        <= cfg_data[TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Delay line memory: written at the head on a tick, read one tap per cycle.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			dl_mem[wp_q] <= noise;
		end
		dl_s1 <= dl_mem[rp_q];
	end

	// Coefficient memory: written by coefficient beats, read one tap per cycle.
	always_ff @(posedge clk) begin
		if (coef_acc && coef_ok) begin
			cf_mem[coef_addr] <= coef_value;
		end
		cf_s1 <= cf_mem[tap_addr];
	end

	// Entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_vld_q <= '0;
			cf_vld_q <= '0;
			dlv_s1   <= 1'b0;
			cfv_s1   <= 1'b0;
			issue_s1 <= 1'b0;
		end else begin
			if (tick_acc) begin
				dl_vld_q[wp_q] <= 1'b1;
			end
			if (coef_acc && coef_ok) begin
				cf_vld_q[coef_addr] <= 1'b1;
			end
			dlv_s1   <= dl_vld_q[rp_q];
			cfv_s1   <= cf_vld_q[tap_addr];
			issue_s1 <= issue;
		end
	end

	// Operands for the shared multiply-accumulate unit.
	assign op_a           = dlv_s1 ? $signed(dl_s1) : '0;
	assign op_b           = cfv_s1 ? $signed(cf_s1) : '0;
	assign mac_ctrl.clear = tick_acc;
	assign mac_ctrl.valid = issue_s1;

	lnf_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (op_a),
		.b      (op_b),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// Shift right by the fraction width, truncating toward zero, then saturate.
	assign acc_rnd = acc + (acc[ACC_W-1] ? RND_NEG : '0);
	assign acc_shf = acc_rnd >>> Q_FRAC;
	always_comb begin
		if (acc_shf > SAT_HI) begin
			sat_val = DATA_W'(SAT_HI);
		end else if (acc_shf < SAT_LO) begin
			sat_val = DATA_W'(SAT_LO);
		end else begin
			sat_val = DATA_W'(acc_shf);
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_DRAIN) && !issue_s1 && !mac_busy && out_free;

	// Sequencer, pointers, LFSR and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lfsr_q      <= LFSR_SEED;
			wp_q        <= '0;
			rp_q        <= '0;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
		end else begin
			// The output beat leaves unless a new sample replaces it at once.
			if (out_valid_q && !out_stall && !finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						lfsr_q  <= {lfsr_q[DATA_W-2:0], fb};
						rp_q    <= wp_q;
						wp_q    <= (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
						k_q     <= '0;
						n_q     <= n_sel;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q  <= k_q + 1'b1;
						rp_q <= (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						sample_q    <= sat_val;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

`ifndef SYNTHESIS
	// The multiplier pipeline only runs while a tick is in progress.
	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_busy |-> in_stall)
		else $error("multiply-accumulate active while input is open");

	// The tap counter never runs past the latched tap count.
	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= n_q)
		else $error("tap counter beyond tap count");

	// A coefficient beat leaves the block ready in the next cycle.
	a_coef_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		coef_acc |=> !in_stall)
		else $error("coefficient write did not complete in one cycle");

	// A result appears only as the drain state completes.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DRAIN))
		else $error("result raised outside the drain state");
`endif

endmodule
